FILE: design/rtt_pkg.sv
package rtt_pkg;

    localparam int COORD_W      = 32;
    localparam int ANGLE_W      = 16;
    localparam int SLOT_W       = 4;
    localparam int CFG_W        = 5;
    localparam int STEP_W       = 5;
    localparam int CORDIC_STEPS = 24;
    localparam int PROD_W       = 2 * COORD_W;

    localparam logic       MODE_PART = 1'b1;

    localparam logic signed [COORD_W-1:0] CORDIC_GAIN   = 32'sd652032874;
    localparam logic        [COORD_W-1:0] PHASE_QUARTER = 32'h4000_0000;
    localparam logic        [COORD_W-1:0] PHASE_HALF    = 32'h8000_0000;
    localparam logic signed [PROD_W-1:0]  ROUND_HALF    = 64'sd536870912;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_SKIP,
        KIND_PART
    } kind_t;

    // data_x/data_y carry the offset for a load, the position for a particle
    typedef struct packed {
        kind_t              kind;
        logic [SLOT_W-1:0]  slot;
        logic [COORD_W-1:0] data_x;
        logic [COORD_W-1:0] data_y;
        logic [COORD_W-1:0] pos_z;
        logic [ANGLE_W-1:0] angle;
        logic               final_part;
        logic [CFG_W-1:0]   count;
    } item_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [ANGLE_W-1:0] angle;
        logic               last;
        logic               bend;
    } result_t;

    // atan(2^-i) as a fraction of a turn, 2^32 per turn
    function automatic logic [COORD_W-1:0] atan_step(input logic [STEP_W-1:0] i);
        logic [COORD_W-1:0] v;
        case (i)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/rtt_fifo.sv
module rtt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty,
    output logic [CNT_W-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: design/rtt_front.sv
module rtt_front #(
    parameter int MAX_CENTERS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        mode,
    input  logic [rtt_pkg::SLOT_W-1:0]  slot,
    input  logic [rtt_pkg::COORD_W-1:0] offset_x,
    input  logic [rtt_pkg::COORD_W-1:0] offset_y,
    input  logic [rtt_pkg::COORD_W-1:0] pos_x,
    input  logic [rtt_pkg::COORD_W-1:0] pos_y,
    input  logic [rtt_pkg::COORD_W-1:0] pos_z,
    input  logic [rtt_pkg::ANGLE_W-1:0] turn_angle,
    input  logic                        final_particle,
    input  logic [rtt_pkg::CFG_W-1:0]   center_count,
    input  logic                        q_pop,
    output rtt_pkg::item_t              q_item,
    output logic                        q_empty
);

    import rtt_pkg::*;

    item_t            cls_item;
    logic [CFG_W-1:0] count_clamped;

    // count 0 acts as 1, above the table size acts as the table size
    always_comb
    begin
        if (center_count == '0)
        begin
            count_clamped = CFG_W'(1);
        end
        else if (32'(center_count) > MAX_CENTERS)
        begin
            count_clamped = CFG_W'(MAX_CENTERS);
        end
        else
        begin
            count_clamped = center_count;
        end
    end

    always_comb
    begin
        cls_item.slot       = slot;
        cls_item.pos_z      = pos_z;
        cls_item.angle      = turn_angle;
        cls_item.final_part = final_particle;
        cls_item.count      = count_clamped;
        if (mode == MODE_PART)
        begin
            cls_item.kind   = KIND_PART;
            cls_item.data_x = pos_x;
            cls_item.data_y = pos_y;
        end
        else
        begin
            // loads past the table end are dropped
            cls_item.kind   = (32'(slot) < MAX_CENTERS) ? KIND_LOAD : KIND_SKIP;
            cls_item.data_x = offset_x;
            cls_item.data_y = offset_y;
        end
    end

    rtt_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (2)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && !full),
        .wr_data (cls_item),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_item),
        .empty   (q_empty),
        .count   ()
    );

endmodule

FILE: design/rtt_back.sv
module rtt_back #(
    parameter int MAX_CENTERS = 16,
    parameter int ANGLE_BITS  = 16,
    parameter int OUT_DEPTH   = 8,
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rtt_pkg::item_t       q_item,
    input  logic                 q_empty,
    output logic                 q_pop,
    input  logic [OUT_CNT_W-1:0] res_count,
    output logic                 res_wr,
    output rtt_pkg::result_t     res_data
);

    import rtt_pkg::*;

    localparam int IDX_W    = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int CNT_W    = $clog2(MAX_CENTERS + 1);
    localparam int ANG_DROP = (ANGLE_BITS < ANGLE_W) ? ANGLE_W - ANGLE_BITS : 0;
    localparam logic [ANGLE_W-1:0] ANG_MASK = {ANGLE_W{1'b1}} << ANG_DROP;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROT,
        ST_EMIT
    } state_t;

    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [CNT_W-1:0]    j_reg;
    logic                v_r_reg, v_m_reg, v_a_reg, v_o_reg;

    logic signed [COORD_W-1:0] x_reg, y_reg, z_reg;
    logic                      flip_reg;
    logic [COORD_W-1:0]        pos_x_reg, pos_y_reg, pos_z_reg;
    logic [ANGLE_W-1:0]        angle_reg;
    logic                      final_reg;
    logic [CFG_W-1:0]          n_reg;

    logic [COORD_W-1:0]        mem_x [MAX_CENTERS];
    logic [COORD_W-1:0]        mem_y [MAX_CENTERS];
    logic signed [COORD_W-1:0] ox_reg, oy_reg;
    logic                      last_r_reg, bend_r_reg;
    logic signed [PROD_W-1:0]  p_cx_reg, p_sy_reg, p_sx_reg, p_cy_reg;
    logic                      last_m_reg, bend_m_reg;
    logic [COORD_W-1:0]        rx_reg, ry_reg;
    logic                      last_a_reg, bend_a_reg;
    result_t                   res_reg;

    logic [2:0]                inflight;
    logic                      credit_ok;
    logic                      issue;
    logic                      last_i;
    logic                      start;
    logic                      tbl_we;
    logic                      rot_done;
    logic [COORD_W-1:0]        phase;
    logic [COORD_W-1:0]        phase_q;
    logic                      fold;
    logic signed [COORD_W-1:0] dx, dy, xn, yn, zn;
    logic [COORD_W-1:0]        atan_v;
    logic signed [PROD_W-1:0]  sum_x, sum_y;

    assign inflight  = 3'($countones({v_r_reg, v_m_reg, v_a_reg, v_o_reg}));
    assign credit_ok = (32'(res_count) + 32'(inflight)) < OUT_DEPTH;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty && (inflight == '0);
    assign start     = q_pop && (q_item.kind == KIND_PART);
    assign tbl_we    = q_pop && (q_item.kind == KIND_LOAD);
    assign issue     = (state_reg == ST_EMIT) && credit_ok;
    assign last_i    = (32'(j_reg) + 1) == 32'(n_reg);
    assign rot_done  = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    // phase setup: fold the half turn so the CORDIC sees [-1/4, 1/4)
    assign phase   = {q_item.angle & ANG_MASK, {(COORD_W - ANGLE_W){1'b0}}};
    assign phase_q = phase + PHASE_QUARTER;
    assign fold    = phase_q[COORD_W-1];

    always_comb
    begin
        dx     = y_reg >>> step_reg;
        dy     = x_reg >>> step_reg;
        atan_v = atan_step(step_reg);
        if (!z_reg[COORD_W-1])
        begin
            xn = x_reg - dx;
            yn = y_reg + dy;
            zn = z_reg - $signed(atan_v);
        end
        else
        begin
            xn = x_reg + dx;
            yn = y_reg - dy;
            zn = z_reg + $signed(atan_v);
        end
    end

    assign sum_x = p_cx_reg - p_sy_reg + ROUND_HALF;
    assign sum_y = p_sx_reg + p_cy_reg + ROUND_HALF;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            j_reg     <= '0;
            v_r_reg   <= 1'b0;
            v_m_reg   <= 1'b0;
            v_a_reg   <= 1'b0;
            v_o_reg   <= 1'b0;
        end
        else
        begin
            v_r_reg <= issue;
            v_m_reg <= v_r_reg;
            v_a_reg <= v_m_reg;
            v_o_reg <= v_a_reg;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_ROT;
                        step_reg  <= '0;
                    end
                end
                ST_ROT:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (rot_done)
                    begin
                        state_reg <= ST_EMIT;
                        j_reg     <= '0;
                    end
                end
                ST_EMIT:
                begin
                    if (issue)
                    begin
                        j_reg <= j_reg + CNT_W'(1);
                        if (last_i)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // CORDIC registers; x/y hold cos/sin once the rotation is done
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg     <= CORDIC_GAIN;
            y_reg     <= '0;
            z_reg     <= fold ? (phase ^ PHASE_HALF) : phase;
            flip_reg  <= fold;
            pos_x_reg <= q_item.data_x;
            pos_y_reg <= q_item.data_y;
            pos_z_reg <= q_item.pos_z;
            angle_reg <= q_item.angle;
            final_reg <= q_item.final_part;
            n_reg     <= q_item.count;
        end
        else if (state_reg == ST_ROT)
        begin
            z_reg <= zn;
            if (rot_done && flip_reg)
            begin
                x_reg <= -xn;
                y_reg <= -yn;
            end
            else
            begin
                x_reg <= xn;
                y_reg <= yn;
            end
        end
    end

    // offset table, registered read
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            mem_x[IDX_W'(q_item.slot)] <= q_item.data_x;
            mem_y[IDX_W'(q_item.slot)] <= q_item.data_y;
        end
        if (issue)
        begin
            ox_reg <= mem_x[j_reg[IDX_W-1:0]];
            oy_reg <= mem_y[j_reg[IDX_W-1:0]];
        end
    end

    // product pipeline: read, multiply, sum and round, add position
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            last_r_reg <= last_i;
            bend_r_reg <= last_i && final_reg;
        end
        p_cx_reg      <= PROD_W'(x_reg) * PROD_W'(ox_reg);
        p_sy_reg      <= PROD_W'(y_reg) * PROD_W'(oy_reg);
        p_sx_reg      <= PROD_W'(y_reg) * PROD_W'(ox_reg);
        p_cy_reg      <= PROD_W'(x_reg) * PROD_W'(oy_reg);
        last_m_reg    <= last_r_reg;
        bend_m_reg    <= bend_r_reg;
        rx_reg        <= sum_x[COORD_W+29:30];
        ry_reg        <= sum_y[COORD_W+29:30];
        last_a_reg    <= last_m_reg;
        bend_a_reg    <= bend_m_reg;
        res_reg.x     <= rx_reg + pos_x_reg;
        res_reg.y     <= ry_reg + pos_y_reg;
        res_reg.z     <= pos_z_reg;
        res_reg.angle <= angle_reg;
        res_reg.last  <= last_a_reg;
        res_reg.bend  <= bend_a_reg;
    end

    assign res_wr   = v_o_reg;
    assign res_data = res_reg;

endmodule

FILE: design/rotate_translate_template.sv
// Channel   Direction  Handshake              Item
// input     in         push / full            load offset or particle
// result    out        pop / empty            one placed template point
// config    in         cfg_we / cfg_data      center_count
//
// A load item is written to the table when the idle, drained back end pops it.
// A particle runs a CORDIC loop of 24 steps, one step a cycle, then n table
// reads and n results (n = clamped center_count), one per cycle while the
// result queue has room, then a pipeline drain. The back end takes the next
// item once its pipeline has drained.
// Reset: center_count is 1, both queues are empty; the offset table holds
// garbage until loaded.
// Stalls: the result queue is 8 deep; table reads pause when queued plus
// in-flight results fill it. The 2-deep input queue raises full.
module rotate_translate_template #(
    parameter int MAX_CENTERS = 16,
    parameter int ANGLE_BITS  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [rtt_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic                        mode,
    input  logic [rtt_pkg::SLOT_W-1:0]  slot,
    input  logic signed [rtt_pkg::COORD_W-1:0] offset_x,
    input  logic signed [rtt_pkg::COORD_W-1:0] offset_y,
    input  logic signed [rtt_pkg::COORD_W-1:0] pos_x,
    input  logic signed [rtt_pkg::COORD_W-1:0] pos_y,
    input  logic signed [rtt_pkg::COORD_W-1:0] pos_z,
    input  logic [rtt_pkg::ANGLE_W-1:0] turn_angle,
    input  logic                        final_particle,
    output logic                        empty,
    input  logic                        pop,
    output logic signed [rtt_pkg::COORD_W-1:0] out_x,
    output logic signed [rtt_pkg::COORD_W-1:0] out_y,
    output logic signed [rtt_pkg::COORD_W-1:0] out_z,
    output logic [rtt_pkg::ANGLE_W-1:0] out_angle,
    output logic                        last_of_run,
    output logic                        batch_end
);

    import rtt_pkg::*;

    localparam int OUT_DEPTH = 8;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    logic [CFG_W-1:0]     center_count_reg;
    item_t                q_item;
    logic                 q_empty;
    logic                 q_pop;
    logic                 res_wr;
    result_t              res_data;
    logic                 res_full;
    logic [OUT_CNT_W-1:0] res_count;
    result_t              res_head;

    // center_count register; the user must write it only while the block is quiet; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_count_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            center_count_reg <= cfg_data;
        end
    end

    // front: classify the item, clamp the count, queue it
    rtt_front #(
        .MAX_CENTERS (MAX_CENTERS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .mode           (mode),
        .slot           (slot),
        .offset_x       (offset_x),
        .offset_y       (offset_y),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .turn_angle     (turn_angle),
        .final_particle (final_particle),
        .center_count   (center_count_reg),
        .q_pop          (q_pop),
        .q_item         (q_item),
        .q_empty        (q_empty)
    );

    // back: table writes, CORDIC, per-offset rotate and translate
    rtt_back #(
        .MAX_CENTERS (MAX_CENTERS),
        .ANGLE_BITS  (ANGLE_BITS),
        .OUT_DEPTH   (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_item    (q_item),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .res_count (res_count),
        .res_wr    (res_wr),
        .res_data  (res_data)
    );

    // result queue, decouples the pipeline from the consumer
    rtt_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_data),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_head),
        .empty   (empty),
        .count   (res_count)
    );

    assign out_x       = res_head.x;
    assign out_y       = res_head.y;
    assign out_z       = res_head.z;
    assign out_angle   = res_head.angle;
    assign last_of_run = res_head.last;
    assign batch_end   = res_head.bend;

    // credit scheme must keep the result queue from overflowing
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_wr && res_full))
        else $error("result written into full queue");

    // batch end only ever rides on the last result of a particle
    a_bend_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && batch_end) |-> last_of_run)
        else $error("batch_end without last_of_run");

    // a particle starts only with the pipeline empty, so no result follows at once
    a_start_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_item.kind == KIND_PART) |=> !res_wr)
        else $error("result emitted right after particle start");

endmodule
